[hw/rtl/lps_pkg.sv]
// Shared constants and types for the lagged product stream.
// No dependencies; used by every other file of the block.
package lps_pkg;

  localparam int MAX_LAG     = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int LAG_W      = 6;                      // lag register width
  localparam int CNT_W      = LAG_W + 1;              // room for seen + 1
  localparam int TAP_IDX_W  = $clog2(MAX_LAG);
  localparam int MUL_W      = 2 * SAMPLE_BITS;
  localparam int PROD_W     = MUL_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LAG_W;

  localparam logic [CFG_IDX_W-1:0] REG_LAG  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REAL = CFG_IDX_W'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One first-signal sample as held in the delay line.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] re;
    logic [SAMPLE_BITS-1:0] im;
    logic                   ok;
  } tap_t;

  // Control from the front end to the delay line.
  typedef struct packed {
    logic                 shift;
    logic [TAP_IDX_W-1:0] sel;
  } dl_ctrl_t;

endpackage

[hw/rtl/lps_in_if.sv]
// Input channel of the lagged product stream: valid/ready plus sample pair.
// Depends on lps_pkg.
interface lps_in_if;
  logic                 valid;
  logic                 ready;
  lps_pkg::sample_t     first_re;
  lps_pkg::sample_t     first_im;
  logic                 first_ok;
  lps_pkg::sample_t     second_re;
  lps_pkg::sample_t     second_im;
  logic                 second_ok;
  logic                 end_of_block;

  modport source (output valid, first_re, first_im, first_ok, second_re, second_im,
                  second_ok, end_of_block, input ready);
  modport sink   (input valid, first_re, first_im, first_ok, second_re, second_im,
                  second_ok, end_of_block, output ready);
endinterface

[hw/rtl/lps_out_if.sv]
// Result channel of the lagged product stream: valid/ready plus product.
// Depends on lps_pkg.
interface lps_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lps_pkg::PROD_W-1:0] prod_re;
  logic signed [lps_pkg::PROD_W-1:0] prod_im;
  logic                              prod_ok;
  logic                              run_last;

  modport source (output valid, prod_re, prod_im, prod_ok, run_last, input ready);
  modport sink   (input valid, prod_re, prod_im, prod_ok, run_last, output ready);
endinterface

[hw/rtl/lps_tap_cell.sv]
// One cell of the first-signal delay line: holds a sample, passes it on.
// Depends on lps_pkg.
module lps_tap_cell (
  input  logic          clk,
  input  logic          shift,
  input  lps_pkg::tap_t d_in,
  output lps_pkg::tap_t q
);

  lps_pkg::tap_t tap_r;

  // Payload only; blocks never read taps they have not written.
  always_ff @(posedge clk) begin
    if (shift) begin
      tap_r <= d_in;
    end
  end

  assign q = tap_r;

endmodule

[hw/rtl/lps_delay_line.sv]
// Row of lps_tap_cell stages with a lag-selected read tap.
// Depends on lps_pkg and lps_tap_cell.
module lps_delay_line (
  input  logic              clk,
  input  lps_pkg::dl_ctrl_t ctrl,
  input  lps_pkg::tap_t     tap_in,
  output lps_pkg::tap_t     tap_out
);

  lps_pkg::tap_t taps [lps_pkg::MAX_LAG];

  genvar g;
  generate
    for (g = 0; g < lps_pkg::MAX_LAG; g++) begin : g_cell
      if (g == 0) begin : g_head
        lps_tap_cell u_cell (
          .clk   (clk),
          .shift (ctrl.shift),
          .d_in  (tap_in),
          .q     (taps[g])
        );
      end else begin : g_body
        lps_tap_cell u_cell (
          .clk   (clk),
          .shift (ctrl.shift),
          .d_in  (taps[g-1]),
          .q     (taps[g])
        );
      end
    end
  endgenerate

  assign tap_out = taps[ctrl.sel];

endmodule

[hw/rtl/lagged_product_stream.sv]
// Lagged product stream: conj(first[k-lag]) * second[k], with end-of-block padding.
// Pipeline: operand registers (loaded at accept), then partial-product and output registers.
// Throughput: 1 item per cycle while results are taken; in complex mode the last item
// of a block is followed by min(items in block, lag capped at MAX_LAG) padding results,
// one per cycle, input held meanwhile.
// Reset: control, lag (0) and mode (complex) cleared; delay line taps are not reset.
// Depends on lps_pkg, lps_in_if, lps_out_if, lps_delay_line.
module lagged_product_stream (
  input  logic                              clk,
  input  logic                              rst_n,
  lps_in_if.sink                            in_ch,
  lps_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LW = lps_pkg::LAG_W;
  localparam int CW = lps_pkg::CNT_W;
  localparam int MW = lps_pkg::MUL_W;
  localparam int PW = lps_pkg::PROD_W;
  localparam int SB = lps_pkg::SAMPLE_BITS;

  // Configuration
  logic [LW-1:0] lag_r;
  logic          real_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r  <= '0;
      real_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        lps_pkg::REG_LAG:  lag_r  <= cfg_data[LW-1:0];
        lps_pkg::REG_REAL: real_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: lag select, block counting, delay line
  logic              in_ready;
  logic              acc;
  logic [LW-1:0]     lag_eff;
  logic [LW-1:0]     lag_m1;
  logic [LW-1:0]     seen_r;
  logic [LW-1:0]     seen_nxt;
  logic [CW-1:0]     seen_p1;
  logic [LW-1:0]     pad_full;
  lps_pkg::tap_t     cur_tap;
  lps_pkg::tap_t     dl_tap;
  lps_pkg::tap_t     del_tap;
  lps_pkg::dl_ctrl_t dl_ctrl;

  assign acc     = in_ch.valid && in_ready;
  assign lag_eff = (lag_r > LW'(lps_pkg::MAX_LAG)) ? LW'(lps_pkg::MAX_LAG) : lag_r;
  assign lag_m1  = lag_eff - LW'(1);
  assign cur_tap = '{re: in_ch.first_re, im: in_ch.first_im, ok: in_ch.first_ok};

  assign dl_ctrl.shift = acc;
  assign dl_ctrl.sel   = lag_m1[lps_pkg::TAP_IDX_W-1:0];

  lps_delay_line u_dl (
    .clk     (clk),
    .ctrl    (dl_ctrl),
    .tap_in  (cur_tap),
    .tap_out (dl_tap)
  );

  assign del_tap  = (lag_eff == '0) ? cur_tap : dl_tap;
  assign seen_p1  = {1'b0, seen_r} + CW'(1);
  assign pad_full = (seen_p1 < {1'b0, lag_eff}) ? seen_p1[LW-1:0] : lag_eff;

  always_comb begin
    seen_nxt = seen_r;
    if (in_ch.end_of_block) begin
      seen_nxt = '0;
    end else if (seen_r < LW'(lps_pkg::MAX_LAG)) begin
      seen_nxt = seen_p1[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (acc) begin
      seen_r <= seen_nxt;
    end
  end

  // Stage 1: operands
  logic                 s1_v_r;
  lps_pkg::tap_t        s1_del_r;
  logic [SB-1:0]        s1_sre_r;
  logic [SB-1:0]        s1_sim_r;
  logic                 s1_sok_r;
  logic                 s1_emit_r;
  logic                 s1_last_r;
  logic [LW-1:0]        s1_pad_r;
  logic                 s1_real_r;

  // Stage 2: partial products and result sequencing
  logic                 s2_v_r;
  logic signed [MW-1:0] s2_prr_r;
  logic signed [MW-1:0] s2_pii_r;
  logic signed [MW-1:0] s2_pri_r;
  logic signed [MW-1:0] s2_pir_r;
  logic                 s2_ok_r;
  logic                 s2_prod_r;
  logic                 s2_last_r;
  logic [LW-1:0]        s2_pad_r;
  logic                 s2_real_r;

  logic signed [MW-1:0] m_rr, m_ii, m_ri, m_ir;
  logic                 s2_has_out;
  logic                 out_free;
  logic                 emit;
  logic                 s2_done;
  logic                 s2_free;
  logic                 s1_free;

  assign out_free   = !out_ch.valid || out_ch.ready;
  assign s2_has_out = s2_prod_r || (s2_pad_r != '0);
  assign emit       = s2_v_r && s2_has_out && out_free;
  // item leaves stage 2 on its final result, or at once if it has none
  assign s2_done    = !s2_has_out ||
                      (out_free && (s2_prod_r ? (s2_pad_r == '0) : (s2_pad_r == LW'(1))));
  assign s2_free    = !s2_v_r || s2_done;
  assign s1_free    = !s1_v_r || s2_free;
  assign in_ready   = s1_free;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_del_r  <= del_tap;
      s1_sre_r  <= in_ch.second_re;
      s1_sim_r  <= in_ch.second_im;
      s1_sok_r  <= in_ch.second_ok;
      s1_emit_r <= seen_r >= lag_eff;
      s1_last_r <= in_ch.end_of_block && (real_r || lag_eff == '0);
      s1_pad_r  <= (in_ch.end_of_block && !real_r) ? pad_full : '0;
      s1_real_r <= real_r;
    end
  end

  assign m_rr = $signed(s1_del_r.re) * $signed(s1_sre_r);
  assign m_ii = $signed(s1_del_r.im) * $signed(s1_sim_r);
  assign m_ri = $signed(s1_del_r.re) * $signed(s1_sim_r);
  assign m_ir = $signed(s1_del_r.im) * $signed(s1_sre_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r    <= 1'b0;
      s2_prod_r <= 1'b0;
      s2_pad_r  <= '0;
    end else if (s2_free) begin
      s2_v_r    <= s1_v_r;
      s2_prod_r <= s1_v_r && s1_emit_r;
      s2_pad_r  <= s1_v_r ? s1_pad_r : '0;
    end else if (emit) begin
      if (s2_prod_r) begin
        s2_prod_r <= 1'b0;
      end else begin
        s2_pad_r <= s2_pad_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_prr_r  <= m_rr;
      s2_pii_r  <= m_ii;
      s2_pri_r  <= m_ri;
      s2_pir_r  <= m_ir;
      s2_ok_r   <= s1_real_r || (s1_del_r.ok && s1_sok_r);
      s2_last_r <= s1_last_r;
      s2_real_r <= s1_real_r;
    end
  end

  // Output register
  logic signed [PW-1:0] rr_x, ii_x, ri_x, ir_x;
  logic signed [PW-1:0] prod_re_val, prod_im_val;
  logic                 out_v_r;
  logic signed [PW-1:0] out_re_r;
  logic signed [PW-1:0] out_im_r;
  logic                 out_ok_r;
  logic                 out_last_r;

  assign rr_x = PW'(s2_prr_r);
  assign ii_x = PW'(s2_pii_r);
  assign ri_x = PW'(s2_pri_r);
  assign ir_x = PW'(s2_pir_r);

  always_comb begin
    if (s2_real_r) begin
      prod_re_val = rr_x;
      prod_im_val = '0;
    end else if (s2_ok_r) begin
      prod_re_val = rr_x + ii_x;
      prod_im_val = ri_x - ir_x;
    end else begin
      prod_re_val = '0;
      prod_im_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (s2_prod_r) begin
        out_re_r   <= prod_re_val;
        out_im_r   <= prod_im_val;
        out_ok_r   <= s2_ok_r;
        out_last_r <= s2_last_r;
      end else begin
        out_re_r   <= '0;
        out_im_r   <= '0;
        out_ok_r   <= 1'b0;
        out_last_r <= s2_pad_r == LW'(1);
      end
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.prod_re  = out_re_r;
  assign out_ch.prod_im  = out_im_r;
  assign out_ch.prod_ok  = out_ok_r;
  assign out_ch.run_last = out_last_r;

  // Checks
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ok_r |-> out_re_r == '0 && out_im_r == '0)
    else $error("cleared-flag result carries nonzero product");

  a_real_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_real_r |-> s2_pad_r == '0)
    else $error("padding pending in real mode");

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LW'(lps_pkg::MAX_LAG))
    else $error("block count beyond maximum lag");

  a_hold_on_pad: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && s2_pad_r > LW'(1) |-> !in_ready)
    else $error("input taken while padding is pending");

endmodule

[verif/lps_product_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the lagged product stream: watches the sample pair channel,
// the register port and the product channel, predicts and compares products.
// Depends on lps_pkg, lps_in_if and lps_out_if.
module lps_product_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  lps_in_if                              in_mon,
  lps_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           run_done,
  output int                             fail_count,
  output int                             pending
);

  typedef logic signed [lps_pkg::PROD_W-1:0] prod_t;

  typedef struct {
    lps_pkg::sample_t re;
    lps_pkg::sample_t im;
    logic             ok;
  } first_tap_t;

  typedef struct {
    prod_t re;
    prod_t im;
    logic  ok;
    logic  last;
  } product_t;

  first_tap_t                first_taps [lps_pkg::MAX_LAG];
  int                        seen_in_block;
  logic [lps_pkg::LAG_W-1:0] lag_reg;
  logic                      real_reg;
  product_t                  expected_products [$];
  bit                        leftover_checked;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_product(input prod_t re, input prod_t im, input logic ok,
                              input logic last);
    product_t p;
    p.re   = re;
    p.im   = im;
    p.ok   = ok;
    p.last = last;
    expected_products.push_back(p);
  endtask

  // Delay the first signal by the lag and form conj(first) * second (real parts only in real mode).
  task automatic predict_products();
    first_tap_t cur;
    first_tap_t del;
    prod_t      fr, fi, sr, si, re_p, im_p;
    int         eff_lag, pad, i;
    logic       pair_ok;
    cur.re  = in_mon.first_re;
    cur.im  = in_mon.first_im;
    cur.ok  = in_mon.first_ok;
    eff_lag = (lag_reg > lps_pkg::MAX_LAG) ? lps_pkg::MAX_LAG : int'(lag_reg);
    del     = (eff_lag == 0) ? cur : first_taps[eff_lag-1];
    for (i = lps_pkg::MAX_LAG - 1; i > 0; i--) first_taps[i] = first_taps[i-1];
    first_taps[0] = cur;

    fr = del.re;
    fi = del.im;
    sr = in_mon.second_re;
    si = in_mon.second_im;
    if (seen_in_block >= eff_lag) begin
      if (real_reg) begin
        push_product(fr * sr, '0, 1'b1, in_mon.end_of_block);
      end else begin
        pair_ok = del.ok & in_mon.second_ok;
        if (pair_ok) begin
          re_p = fr * sr + fi * si;
          im_p = fr * si - fi * sr;
        end else begin
          re_p = '0;
          im_p = '0;
        end
        push_product(re_p, im_p, pair_ok, in_mon.end_of_block && eff_lag == 0);
      end
    end

    if (in_mon.end_of_block) begin
      // complex mode pads so the block yields one entry per item
      if (!real_reg) begin
        pad = (seen_in_block + 1 < eff_lag) ? seen_in_block + 1 : eff_lag;
        for (i = 0; i < pad; i++) push_product('0, '0, 1'b0, i + 1 == pad);
      end
      seen_in_block = 0;
    end else if (seen_in_block < lps_pkg::MAX_LAG) begin
      seen_in_block++;
    end
  endtask

  task automatic check_product();
    product_t want;
    if (expected_products.size() == 0) begin
      report_mismatch($sformatf("unexpected product re=%0d im=%0d ok=%0b last=%0b",
                                out_mon.prod_re, out_mon.prod_im, out_mon.prod_ok,
                                out_mon.run_last));
      return;
    end
    want = expected_products.pop_front();
    if (out_mon.prod_re !== want.re)
      report_mismatch($sformatf("prod_re got %0d want %0d", out_mon.prod_re, want.re));
    if (out_mon.prod_im !== want.im)
      report_mismatch($sformatf("prod_im got %0d want %0d", out_mon.prod_im, want.im));
    if (out_mon.prod_ok !== want.ok)
      report_mismatch($sformatf("prod_ok got %0b want %0b", out_mon.prod_ok, want.ok));
    if (out_mon.run_last !== want.last)
      report_mismatch($sformatf("run_last got %0b want %0b", out_mon.run_last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seen_in_block = 0;
      lag_reg       = '0;
      real_reg      = 1'b0;
      expected_products.delete();
    end else begin
      // compare first so a stray product is never matched to a fresh item
      if (out_mon.valid && out_mon.ready) check_product();
      if (cfg_we) begin
        if (cfg_idx == lps_pkg::REG_LAG) lag_reg = cfg_data;
        else if (cfg_idx == lps_pkg::REG_REAL) real_reg = cfg_data[0];
      end
      if (in_mon.valid && in_mon.ready) predict_products();
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_products.size() != 0)
          report_mismatch($sformatf("%0d expected products never arrived",
                                    expected_products.size()));
      end
    end
    pending = expected_products.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Top of the lagged product stream bench: clock, reset, register writes, sample
// pair stimulus and product back-pressure; verdict from lps_product_checker.
// Depends on lps_pkg, lps_in_if, lps_out_if and lagged_product_stream.
module testbench;

  localparam int IDX_W            = lps_pkg::CFG_IDX_W;
  localparam int DATA_W           = lps_pkg::CFG_DATA_W;
  localparam int MAX_LAG          = lps_pkg::MAX_LAG;
  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 9;
  localparam int SETTLE_CYCLES    = 8;     // extra wait once every expected product has drained
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int RANDOM_ITEMS     = 130;

  // indexes past the last register, writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(3);

  localparam lps_pkg::sample_t S_MIN = lps_pkg::sample_t'(16'h8000);
  localparam lps_pkg::sample_t S_MAX = lps_pkg::sample_t'(16'h7FFF);

  typedef struct {
    lps_pkg::sample_t first_re;
    lps_pkg::sample_t first_im;
    logic             first_ok;
    lps_pkg::sample_t second_re;
    lps_pkg::sample_t second_im;
    logic             second_ok;
  } pair_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_idx;
  logic [DATA_W-1:0] cfg_data;
  logic              run_done;
  int                fail_count;
  int                pending;

  bit no_idle      = 1'b0;
  bit long_hold    = 1'b0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  lps_in_if  in_ch ();
  lps_out_if out_ch ();

  lagged_product_stream u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  lps_product_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .run_done   (run_done),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic lps_pkg::sample_t rand_sample();
    case ($urandom_range(0, 11))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return '0;
      3:       return '1;
      default: return lps_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic pair_t make_pair(input lps_pkg::sample_t fr, input lps_pkg::sample_t fi,
                                      input logic fo,
                                      input lps_pkg::sample_t sr, input lps_pkg::sample_t si,
                                      input logic so);
    pair_t p;
    p.first_re  = fr;
    p.first_im  = fi;
    p.first_ok  = fo;
    p.second_re = sr;
    p.second_im = si;
    p.second_ok = so;
    return p;
  endfunction

  function automatic pair_t rand_pair(input int ok_pct);
    return make_pair(rand_sample(), rand_sample(), $urandom_range(1, 100) <= ok_pct,
                     rand_sample(), rand_sample(), $urandom_range(1, 100) <= ok_pct);
  endfunction

  // Offer one item, possibly after an idle burst, and wait for its accept.
  task automatic send_pair(input pair_t p, input logic eob);
    if (!no_idle && $urandom_range(1, 100) <= src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.first_re     <= p.first_re;
    in_ch.first_im     <= p.first_im;
    in_ch.first_ok     <= p.first_ok;
    in_ch.second_re    <= p.second_re;
    in_ch.second_im    <= p.second_im;
    in_ch.second_ok    <= p.second_ok;
    in_ch.end_of_block <= eob;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_block(input int len, input int ok_pct);
    int k;
    for (k = 0; k < len; k++) send_pair(rand_pair(ok_pct), k == len - 1);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Called on the accept edge of the last item: stop offering, let every
  // expected product drain, then give the pipeline a few more cycles.
  task automatic wait_idle();
    int n;
    in_ch.valid <= 1'b0;
    n = 0;
    @(negedge clk);
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (!no_idle && $urandom_range(1, 100) <= snk_idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int   lag_val, eff, len, ok_pct, phase, phase_items, random_sent;
    logic mode;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_data           <= '0;
    run_done           <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.first_re     <= '0;
    in_ch.first_im     <= '0;
    in_ch.first_ok     <= 1'b0;
    in_ch.second_re    <= '0;
    in_ch.second_im    <= '0;
    in_ch.second_ok    <= 1'b0;
    in_ch.end_of_block <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lag 0, complex: corner magnitudes and each flag cleared once
    send_pair(make_pair(S_MIN, S_MIN, 1'b1, S_MIN, S_MIN, 1'b1), 1'b0);
    send_pair(make_pair(S_MAX, S_MIN, 1'b1, S_MIN, S_MAX, 1'b1), 1'b0);
    send_pair(make_pair(S_MAX, S_MAX, 1'b0, 16'sd1234, -16'sd1, 1'b1), 1'b0);
    send_pair(make_pair(-16'sd1, 16'sd1, 1'b1, S_MAX, S_MAX, 1'b0), 1'b1);
    wait_idle();

    // lag 3: block shorter than the lag (padding only), then a longer one
    write_reg(lps_pkg::REG_LAG, DATA_W'(3));
    send_block(2, 100);
    send_block(5, 100);
    wait_idle();

    // stray register indexes, then a lag above the maximum
    write_reg(REG_SPARE_A, DATA_W'(63));
    write_reg(REG_SPARE_B, DATA_W'(42));
    write_reg(lps_pkg::REG_LAG, DATA_W'(63));
    send_block(1, 100);
    wait_idle();

    // real mode: flags and imaginary parts ignored, no padding
    write_reg(lps_pkg::REG_REAL, DATA_W'(1));
    write_reg(lps_pkg::REG_LAG, DATA_W'(2));
    send_pair(make_pair(S_MIN, S_MAX, 1'b0, S_MIN, S_MIN, 1'b0), 1'b0);
    send_pair(make_pair(S_MAX, S_MIN, 1'b1, S_MAX, 16'sd0, 1'b0), 1'b0);
    send_pair(make_pair(16'sd7, -16'sd3, 1'b0, S_MIN, S_MAX, 1'b1), 1'b1);
    send_block(1, 50);    // too short for a product: nothing comes out
    wait_idle();
    write_reg(lps_pkg::REG_LAG, DATA_W'(0));
    send_pair(make_pair(S_MIN, S_MAX, 1'b1, S_MAX, S_MIN, 1'b0), 1'b0);
    send_pair(make_pair(S_MIN, S_MIN, 1'b0, S_MIN, S_MAX, 1'b1), 1'b1);
    wait_idle();

    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          lag_val = MAX_LAG;
          mode    = 1'b0;
        end
        1: begin
          lag_val = 45;
          mode    = 1'b1;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       lag_val = 0;
            1:       lag_val = 1;
            2:       lag_val = 63;
            3:       lag_val = MAX_LAG;
            default: lag_val = $urandom_range(2, 12);
          endcase
          mode = $urandom_range(0, 1);
        end
      endcase
      no_idle      = (random_sent >= RANDOM_ITEMS - 40);
      src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      snk_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      ok_pct       = $urandom_range(50, 100);
      write_reg(lps_pkg::REG_LAG, DATA_W'(lag_val));
      write_reg(lps_pkg::REG_REAL, DATA_W'(mode));
      if (phase == 0) begin
        // sink stalls for a long stretch while items keep coming
        src_idle_pct = 0;
        long_hold    = 1'b1;
      end
      eff         = (lag_val > MAX_LAG) ? MAX_LAG : lag_val;
      phase_items = 0;
      while (phase_items < 20) begin
        if ($urandom_range(0, 3) == 0) len = $urandom_range(1, (eff > 0) ? eff : 3);
        else len = eff + $urandom_range(1, 8);
        send_block(len, ok_pct);
        phase_items += len;
      end
      random_sent += phase_items;
      wait_idle();
      phase++;
    end

    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("Timeout: stimulus or products stuck");
    $display("Some tests failed");
    $finish;
  end

endmodule
